// ===== rtl/itcf_pkg.sv =====
package itcf_pkg;

    // Raw sensor words and the angle format (degrees with ANGLE_FRAC fraction bits).
    localparam int RAW_W      = 16;
    localparam int ANGLE_FRAC = 16;
    localparam int ANGLE_W    = 9 + ANGLE_FRAC;

    // CORDIC working widths: x and y are pre-scaled by 2^PRE_SHIFT, and z is kept
    // in degrees with ZACC_FRAC fraction bits.
    localparam int PRE_SHIFT   = 14;
    localparam int XY_W        = 32;
    localparam int ZACC_FRAC   = 24;
    localparam int ZACC_W      = 34;
    localparam int ATAN_LEN    = 24;
    localparam int ATAN_IDX_W  = 5;
    localparam int ATAN_W      = 30;
    localparam int ROUND_SHIFT = ZACC_FRAC - ANGLE_FRAC;

    localparam logic signed [ZACC_W-1:0] Z_HALF_TURN = 34'sd3019898880;
    localparam logic signed [ZACC_W-1:0] Z_ROUND_HALF =
        ZACC_W'(64'sd1 <<< (ROUND_SHIFT - 1));

    // Blend arithmetic.
    localparam int ALPHA_W     = 16;
    localparam int WIDE_W      = 48;
    localparam int BLEND_SHIFT = ALPHA_W;
    localparam logic signed [WIDE_W-1:0] BLEND_HALF = 48'sd32768;
    localparam logic [ALPHA_W:0] ALPHA_ONE = 17'h10000;

    // Configuration registers.
    localparam int SCALE_W    = 10;
    localparam int THR_W      = 24;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 25;

    localparam logic [CFG_IDX_W-1:0] CFG_GYRO_OFFSET  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ACCEL_OFFSET = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ALPHA        = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_GYRO_SCALE   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_FALL_THR     = 3'd4;

    localparam logic [ALPHA_W-1:0] ALPHA_RESET = 16'd655;
    localparam logic [SCALE_W-1:0] SCALE_RESET = 10'd20;
    localparam logic [THR_W-1:0]   THR_RESET   = 24'd3276800;

    typedef enum logic [3:0] {
        S_IDLE,
        S_INIT,
        S_ITER,
        S_ROUND,
        S_RATE,
        S_GYRO,
        S_ALPHA,
        S_BLEND,
        S_DONE
    } t_state;

    typedef struct packed {
        logic load;
        logic cordic_init;
        logic cordic_step;
        logic round;
        logic mul_rate;
        logic gyro_sum;
        logic mul_alpha;
        logic blend;
        logic commit;
    } t_dp_cmd;

    typedef struct packed {
        logic fault;
        logic axis_zero;
        logic iter_last;
    } t_dp_status;

    // atan(2^-i) in degrees with ZACC_FRAC fraction bits.
    function automatic logic [ATAN_W-1:0] atan_entry(input logic [ATAN_IDX_W-1:0] idx);
        logic [ATAN_W-1:0] val;
        unique case (idx)
            5'd0:    val = 30'd754974720;
            5'd1:    val = 30'd445687602;
            5'd2:    val = 30'd235489088;
            5'd3:    val = 30'd119537938;
            5'd4:    val = 30'd60000934;
            5'd5:    val = 30'd30029717;
            5'd6:    val = 30'd15018523;
            5'd7:    val = 30'd7509720;
            5'd8:    val = 30'd3754917;
            5'd9:    val = 30'd1877466;
            5'd10:   val = 30'd938734;
            5'd11:   val = 30'd469367;
            5'd12:   val = 30'd234684;
            5'd13:   val = 30'd117342;
            5'd14:   val = 30'd58671;
            5'd15:   val = 30'd29335;
            5'd16:   val = 30'd14668;
            5'd17:   val = 30'd7334;
            5'd18:   val = 30'd3667;
            5'd19:   val = 30'd1833;
            5'd20:   val = 30'd917;
            5'd21:   val = 30'd458;
            5'd22:   val = 30'd229;
            5'd23:   val = 30'd115;
            default: val = '0;
        endcase
        return val;
    endfunction

    // Clamp a wide signed value to the angle range.
    function automatic logic signed [ANGLE_W-1:0] sat_angle(
        input logic signed [WIDE_W-1:0] v
    );
        logic signed [WIDE_W-1:0] amax;
        logic signed [WIDE_W-1:0] amin;
        logic signed [ANGLE_W-1:0] res;
        amax = (48'sd1 <<< (ANGLE_W - 1)) - 48'sd1;
        amin = -amax - 48'sd1;
        if (v > amax) begin
            res = ANGLE_W'(amax);
        end else if (v < amin) begin
            res = ANGLE_W'(amin);
        end else begin
            res = ANGLE_W'(v);
        end
        return res;
    endfunction

endpackage

// ===== rtl/itcf_sample_if.sv =====
interface itcf_sample_if import itcf_pkg::*; ();
    logic                    valid;
    logic                    ready;
    logic signed [RAW_W-1:0] accel_x;
    logic signed [RAW_W-1:0] accel_y;
    logic signed [RAW_W-1:0] accel_z;
    logic signed [RAW_W-1:0] rate_x;
    logic signed [RAW_W-1:0] rate_y;
    logic signed [RAW_W-1:0] rate_z;

    modport source (
        output valid, accel_x, accel_y, accel_z, rate_x, rate_y, rate_z,
        input  ready
    );
    modport sink (
        input  valid, accel_x, accel_y, accel_z, rate_x, rate_y, rate_z,
        output ready
    );
endinterface

// ===== rtl/itcf_result_if.sv =====
interface itcf_result_if import itcf_pkg::*; ();
    logic                      valid;
    logic                      ready;
    logic signed [ANGLE_W-1:0] tilt_angle;
    logic signed [ANGLE_W-1:0] accel_tilt;
    logic                      sensor_fault;
    logic                      fallen;

    modport source (
        output valid, tilt_angle, accel_tilt, sensor_fault, fallen,
        input  ready
    );
    modport sink (
        input  valid, tilt_angle, accel_tilt, sensor_fault, fallen,
        output ready
    );
endinterface

// ===== rtl/itcf_datapath.sv =====
module itcf_datapath import itcf_pkg::*; #(
    parameter int CORDIC_STEPS = 16
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic signed [RAW_W-1:0]   i_accel_x,
    input  logic signed [RAW_W-1:0]   i_accel_y,
    input  logic signed [RAW_W-1:0]   i_accel_z,
    input  logic signed [RAW_W-1:0]   i_rate_x,
    input  logic signed [RAW_W-1:0]   i_rate_y,
    input  logic signed [RAW_W-1:0]   i_rate_z,
    input  logic                      i_cfg_we,
    input  logic [CFG_IDX_W-1:0]      i_cfg_idx,
    input  logic [CFG_DATA_W-1:0]     i_cfg_data,
    input  t_dp_cmd                   i_cmd,
    output t_dp_status                o_status,
    output logic signed [ANGLE_W-1:0] o_tilt_angle,
    output logic signed [ANGLE_W-1:0] o_accel_tilt,
    output logic                      o_sensor_fault,
    output logic                      o_fallen
);

    localparam int CNT_W = (CORDIC_STEPS > 1) ? $clog2(CORDIC_STEPS) : 1;
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(CORDIC_STEPS - 1);

    // Configuration.
    logic signed [RAW_W-1:0]   r_gyro_offset;
    logic signed [ANGLE_W-1:0] r_accel_offset;
    logic [ALPHA_W-1:0]        r_alpha;
    logic [SCALE_W-1:0]        r_scale;
    logic [THR_W-1:0]          r_threshold;

    // Kept angle and result word.
    logic signed [ANGLE_W-1:0] r_filtered;
    logic signed [ANGLE_W-1:0] r_tilt_out;
    logic signed [ANGLE_W-1:0] r_acc_out;
    logic                      r_fault_out;
    logic                      r_fallen_out;

    // Working registers.
    logic signed [RAW_W-1:0]   r_ax;
    logic signed [RAW_W-1:0]   r_az;
    logic signed [RAW_W-1:0]   r_gy;
    logic                      r_fault;
    logic signed [XY_W-1:0]    r_x;
    logic signed [XY_W-1:0]    r_y;
    logic signed [ZACC_W-1:0]  r_z;
    logic [CNT_W-1:0]          r_cnt;
    logic signed [ANGLE_W-1:0] r_acc;
    logic signed [27:0]        r_rate_prod;
    logic signed [27:0]        r_gyro;
    logic signed [41:0]        r_alpha_prod;
    logic signed [WIDE_W-1:0]  r_blend;

    logic signed [XY_W-1:0]    x_pre;
    logic signed [XY_W-1:0]    y_pre;
    logic signed [XY_W-1:0]    x_sh;
    logic signed [XY_W-1:0]    y_sh;
    logic signed [ZACC_W-1:0]  atan_z;
    logic signed [ZACC_W-1:0]  z_round;
    logic signed [WIDE_W-1:0]  acc_wide;
    logic signed [RAW_W:0]     rate_diff;
    logic signed [27:0]        rate_prod;
    logic signed [27:0]        gyro_sum;
    logic signed [41:0]        alpha_prod;
    logic [ALPHA_W:0]          beta;
    logic signed [45:0]        beta_prod;
    logic signed [WIDE_W-1:0]  blend_sum;
    logic signed [ANGLE_W-1:0] new_angle;
    logic [ANGLE_W-1:0]        new_mag;
    logic                      fallen_c;
    logic                      all_zero;

    assign all_zero = (i_accel_x == '0) && (i_accel_y == '0) && (i_accel_z == '0)
                   && (i_rate_x == '0) && (i_rate_y == '0) && (i_rate_z == '0);

    assign x_pre  = XY_W'(r_az) <<< PRE_SHIFT;
    assign y_pre  = XY_W'(r_ax) <<< PRE_SHIFT;
    assign x_sh   = r_x >>> r_cnt;
    assign y_sh   = r_y >>> r_cnt;
    assign atan_z = signed'(ZACC_W'(atan_entry(ATAN_IDX_W'(r_cnt))));

    assign z_round  = (r_z + Z_ROUND_HALF) >>> ROUND_SHIFT;
    assign acc_wide = -WIDE_W'(z_round) - WIDE_W'(r_accel_offset);

    assign rate_diff = (RAW_W + 1)'(r_gy) - (RAW_W + 1)'(r_gyro_offset);
    assign rate_prod = 28'(rate_diff) * 28'(signed'({1'b0, r_scale}));
    assign gyro_sum  = 28'(r_filtered) + r_rate_prod;

    assign alpha_prod = 42'(signed'({1'b0, r_alpha})) * 42'(r_acc);
    assign beta       = ALPHA_ONE - {1'b0, r_alpha};
    assign beta_prod  = 46'(signed'({1'b0, beta})) * 46'(r_gyro);
    assign blend_sum  = WIDE_W'(beta_prod) + WIDE_W'(r_alpha_prod) + BLEND_HALF;

    assign new_angle = sat_angle(r_blend >>> BLEND_SHIFT);
    assign new_mag   = new_angle[ANGLE_W-1] ? ANGLE_W'(-new_angle) : ANGLE_W'(new_angle);
    assign fallen_c  = new_mag > {1'b0, r_threshold};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gyro_offset  <= '0;
            r_accel_offset <= '0;
            r_alpha        <= ALPHA_RESET;
            r_scale        <= SCALE_RESET;
            r_threshold    <= THR_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_GYRO_OFFSET:  r_gyro_offset  <= RAW_W'(i_cfg_data);
                CFG_ACCEL_OFFSET: r_accel_offset <= ANGLE_W'(i_cfg_data);
                CFG_ALPHA:        r_alpha        <= ALPHA_W'(i_cfg_data);
                CFG_GYRO_SCALE:   r_scale        <= SCALE_W'(i_cfg_data);
                CFG_FALL_THR:     r_threshold    <= THR_W'(i_cfg_data);
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_filtered   <= '0;
            r_tilt_out   <= '0;
            r_acc_out    <= '0;
            r_fault_out  <= 1'b0;
            r_fallen_out <= 1'b0;
        end else if (i_cmd.commit) begin
            if (r_fault) begin
                r_tilt_out   <= r_filtered;
                r_acc_out    <= '0;
                r_fault_out  <= 1'b1;
                r_fallen_out <= 1'b0;
            end else begin
                r_filtered   <= new_angle;
                r_tilt_out   <= new_angle;
                r_acc_out    <= r_acc;
                r_fault_out  <= 1'b0;
                r_fallen_out <= fallen_c;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_ax    <= i_accel_x;
            r_az    <= i_accel_z;
            r_gy    <= i_rate_y;
            r_fault <= all_zero;
        end
        if (i_cmd.cordic_init) begin
            r_cnt <= '0;
            if (r_ax == '0) begin
                // On the x axis the angle is exact: zero or a half turn.
                r_z <= (r_az < 0) ? Z_HALF_TURN : '0;
            end else if (r_az < 0) begin
                // Left half plane: rotate by a half turn first.
                r_z <= (r_ax > 0) ? Z_HALF_TURN : -Z_HALF_TURN;
                r_x <= -x_pre;
                r_y <= -y_pre;
            end else begin
                r_z <= '0;
                r_x <= x_pre;
                r_y <= y_pre;
            end
        end
        if (i_cmd.cordic_step) begin
            r_cnt <= r_cnt + 1'b1;
            if (r_y > 0) begin
                r_x <= r_x + y_sh;
                r_y <= r_y - x_sh;
                r_z <= r_z + atan_z;
            end else begin
                r_x <= r_x - y_sh;
                r_y <= r_y + x_sh;
                r_z <= r_z - atan_z;
            end
        end
        if (i_cmd.round) begin
            r_acc <= sat_angle(acc_wide);
        end
        if (i_cmd.mul_rate) begin
            r_rate_prod <= rate_prod;
        end
        if (i_cmd.gyro_sum) begin
            r_gyro <= gyro_sum;
        end
        if (i_cmd.mul_alpha) begin
            r_alpha_prod <= alpha_prod;
        end
        if (i_cmd.blend) begin
            r_blend <= blend_sum;
        end
    end

    assign o_status.fault     = r_fault;
    assign o_status.axis_zero = (r_ax == '0);
    assign o_status.iter_last = (r_cnt == CNT_LAST);

    assign o_tilt_angle   = r_tilt_out;
    assign o_accel_tilt   = r_acc_out;
    assign o_sensor_fault = r_fault_out;
    assign o_fallen       = r_fallen_out;

    a_fault_keeps_angle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.commit && r_fault) |=>
            (r_tilt_out == r_filtered && r_acc_out == '0 && !r_fallen_out))
        else $error("fault word did not report the kept angle");

    a_fallen_not_fault: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fallen_out |-> !r_fault_out)
        else $error("fall flagged on a fault word");

    a_iter_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.cordic_step |-> (r_cnt <= CNT_LAST))
        else $error("CORDIC iteration beyond the last step");

endmodule

// ===== rtl/itcf_ctrl.sv =====
module itcf_ctrl import itcf_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_ready,
    output logic       o_out_valid,
    input  logic       i_out_ready,
    input  t_dp_status i_status,
    output t_dp_cmd    o_cmd
);

    t_state r_state;
    t_state n_state;
    logic   r_out_valid;
    logic   out_free;

    assign out_free = !r_out_valid || i_out_ready;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) n_state = S_INIT;
            end
            S_INIT: begin
                if (i_status.fault) begin
                    n_state = S_DONE;
                end else if (i_status.axis_zero) begin
                    n_state = S_ROUND;
                end else begin
                    n_state = S_ITER;
                end
            end
            S_ITER: begin
                if (i_status.iter_last) n_state = S_ROUND;
            end
            S_ROUND: n_state = S_RATE;
            S_RATE:  n_state = S_GYRO;
            S_GYRO:  n_state = S_ALPHA;
            S_ALPHA: n_state = S_BLEND;
            S_BLEND: n_state = S_DONE;
            S_DONE: begin
                if (out_free) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_cmd      = '0;
        o_in_ready = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                o_cmd.load = i_in_valid;
            end
            S_INIT:  o_cmd.cordic_init = !i_status.fault;
            S_ITER:  o_cmd.cordic_step = 1'b1;
            S_ROUND: o_cmd.round       = 1'b1;
            S_RATE:  o_cmd.mul_rate    = 1'b1;
            S_GYRO:  o_cmd.gyro_sum    = 1'b1;
            S_ALPHA: o_cmd.mul_alpha   = 1'b1;
            S_BLEND: o_cmd.blend       = 1'b1;
            S_DONE:  o_cmd.commit      = out_free;
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (o_cmd.commit) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_out_valid = r_out_valid;

    a_commit_into_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.commit |-> (!r_out_valid || i_out_ready))
        else $error("result word overwritten before it was taken");

    a_iter_exit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_ITER && i_status.iter_last) |=> (r_state == S_ROUND))
        else $error("CORDIC loop did not end after its last step");

endmodule

// ===== rtl/imu_tilt_complementary_filter_top.sv =====
// Tilt estimator for a six-axis inertial sensor. Each sample word gives one result
// word. The accelerometer tilt is -atan2(accel_x, accel_z) in degrees, found by an
// iterative vectoring CORDIC, minus accel_angle_offset; the Y rate, less gyro_offset
// and scaled by gyro_scale, is added to the kept angle, and the two are blended by
// filter_alpha (a fraction of 65536 given to the accelerometer). Angles are signed,
// 16 fraction bits per degree, and saturate at -256 and just under +256 degrees.
// fallen is raised when the new angle's magnitude exceeds fall_threshold. A sample
// whose six readings are all zero is reported as a sensor fault: the kept angle is
// returned unchanged with accel_tilt and fallen at zero. Samples are taken one at a
// time. A normal sample runs CORDIC_STEPS micro-rotations (16 by default) in the
// CORDIC unit, which performs one micro-rotation per cycle, and then the rounding,
// rate multiply, gyro sum, alpha multiply and blend steps before its result is
// committed. A sample with accel_x zero skips the rotations, and a fault sample
// also skips the later steps. The result word sits in an output register, so a new
// sample is accepted while the previous result still waits to be taken; if it has
// not been taken when the next one is ready, the block waits with that next result.
// Configuration registers are written through the plain write port: index 0
// gyro_offset, 1 accel_angle_offset, 2 filter_alpha, 3 gyro_scale, 4 fall_threshold;
// other indexes are ignored. Write them only while the block is idle.
module imu_tilt_complementary_filter_top import itcf_pkg::*; #(
    parameter int CORDIC_STEPS = 16
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    itcf_sample_if.sink           i_sample,
    itcf_result_if.source         o_result,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    // Commands from the sequencer to the datapath and status flags back.
    t_dp_cmd    dp_cmd;
    t_dp_status dp_status;

    // The sequencer owns the handshakes: it takes a sample word only when idle and
    // raises the result valid flag when the datapath has loaded the result word.
    itcf_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_sample.valid),
        .o_in_ready  (i_sample.ready),
        .o_out_valid (o_result.valid),
        .i_out_ready (o_result.ready),
        .i_status    (dp_status),
        .o_cmd       (dp_cmd)
    );

    // The datapath holds the configuration, the kept angle, the CORDIC registers,
    // the blend arithmetic and the result register.
    itcf_datapath #(
        .CORDIC_STEPS (CORDIC_STEPS)
    ) u_datapath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_accel_x      (i_sample.accel_x),
        .i_accel_y      (i_sample.accel_y),
        .i_accel_z      (i_sample.accel_z),
        .i_rate_x       (i_sample.rate_x),
        .i_rate_y       (i_sample.rate_y),
        .i_rate_z       (i_sample.rate_z),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_idx      (i_cfg_idx),
        .i_cfg_data     (i_cfg_data),
        .i_cmd          (dp_cmd),
        .o_status       (dp_status),
        .o_tilt_angle   (o_result.tilt_angle),
        .o_accel_tilt   (o_result.accel_tilt),
        .o_sensor_fault (o_result.sensor_fault),
        .o_fallen       (o_result.fallen)
    );

endmodule
